// ===== rtl/bffa_pkg.sv =====
// Shared types, codes and constants for the first-fit bitmap allocator.
`default_nettype none

package bffa_pkg;

    localparam int CAP_W    = 14;
    localparam int NUM_W    = 14;
    localparam int STATUS_W = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 14'd8192;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL         = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd3;

    typedef struct packed {
        logic             op;
        logic [NUM_W-1:0] entry_number;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NUM_W-1:0]    allocated_number;
        logic [NUM_W-1:0]    free_count;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load;
        logic                advance;
        logic                clear;
        logic                rd_cur;
        logic                rd_next;
        logic                wr_set;
        logic                wr_clr;
        logic                emit;
        logic                grant;
        logic [STATUS_W-1:0] status;
    } dp_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic found;
        logic scan_end;
        logic last_word;
        logic idx_here;
        logic bit_set;
        logic range_bad;
    } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/bffa_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module bffa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/bffa_ctrl.sv =====
// Controller state machine of the bitmap allocator: clearing pass, scan and free sequencing.
`default_nettype none

module bffa_ctrl
    import bffa_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire logic    op,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd,
    output logic         busy
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_ACHK = 3'd2;
    localparam logic [2:0] S_SEEK = 3'd3;
    localparam logic [2:0] S_FCHK = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        cmd.status = ST_OK;
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.clear = 1'b1;
                if (sts.last_word)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            S_IDLE:
            begin
                // Word 0 is always being read here, so a scan can start at once.
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (op == OP_ALLOC)
                    begin
                        state_next = S_ACHK;
                    end
                    else if (sts.range_bad)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.status = ST_OUT_OF_RANGE;
                    end
                    else
                    begin
                        state_next = S_SEEK;
                    end
                end
            end
            S_ACHK:
            begin
                cmd.rd_next = 1'b1;
                if (sts.found)
                begin
                    cmd.wr_set = 1'b1;
                    cmd.emit   = 1'b1;
                    cmd.grant  = 1'b1;
                    cmd.status = ST_OK;
                    state_next = S_IDLE;
                end
                else if (sts.scan_end)
                begin
                    cmd.emit   = 1'b1;
                    cmd.status = ST_FULL;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            S_SEEK:
            begin
                if (sts.idx_here)
                begin
                    cmd.rd_cur = 1'b1;
                    state_next = S_FCHK;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            S_FCHK:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
                if (sts.bit_set)
                begin
                    cmd.wr_clr = 1'b1;
                    cmd.status = ST_OK;
                end
                else
                begin
                    cmd.status = ST_ALREADY_FREE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bffa_dp.sv =====
// Datapath of the bitmap allocator: capacity register, word walker, bitmap RAM and result register.
`default_nettype none

module bffa_dp
    import bffa_pkg::*;
#(
    parameter int MAP_BITS  = 8192,
    parameter int WORD_BITS = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CAP_W-1:0] cfg_wdata,
    input  wire in_item_t         item,
    input  wire dp_cmd_t          cmd,
    output dp_sts_t               sts,
    output logic                  done,
    output result_t               result
);

    localparam int NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int OW        = $clog2(WORD_BITS);
    localparam int UCW       = $clog2(MAP_BITS + 1);
    localparam int XW        = ((UCW > CAP_W) ? UCW : CAP_W) + 1;

    localparam logic [AW-1:0]  LAST_WORD = AW'(NUM_WORDS - 1);
    localparam logic [XW-1:0]  MAP_X     = XW'(MAP_BITS);
    localparam logic [XW-1:0]  WORD_X    = XW'(WORD_BITS);
    localparam logic [UCW-1:0] MAP_U     = UCW'(MAP_BITS);

    logic [CAP_W-1:0]     capacity_reg;
    logic [AW-1:0]        word_reg;
    logic [AW-1:0]        word_next;
    logic [XW-1:0]        base_reg;
    logic [XW-1:0]        base_next;
    logic [XW-1:0]        idx_reg;
    logic [UCW-1:0]       used_reg;
    logic [UCW-1:0]       used_next;
    logic                 done_reg;
    result_t              result_reg;
    result_t              result_next;

    logic [XW-1:0]        cap_eff;
    logic [XW-1:0]        remain;
    logic [XW-1:0]        base_end;
    logic [XW-1:0]        num_in;
    logic [XW-1:0]        used_x;
    logic [XW-1:0]        free_x;
    logic [WORD_BITS-1:0] rdata;
    logic [WORD_BITS-1:0] wdata;
    logic [WORD_BITS-1:0] avail;
    logic [WORD_BITS-1:0] set_mask;
    logic [WORD_BITS-1:0] clr_mask;
    logic [OW-1:0]        pick;
    logic [OW-1:0]        off;
    logic                 found;
    logic [AW-1:0]        raddr;
    logic [AW-1:0]        word_ahead;
    logic                 we;

    // A capacity above the map size is clipped to the map size.
    assign cap_eff  = (XW'(capacity_reg) > MAP_X) ? MAP_X : XW'(capacity_reg);
    assign base_end = base_reg + WORD_X;
    assign remain   = (cap_eff > base_reg) ? (cap_eff - base_reg) : '0;

    // Candidate bits are clear and lie below the effective capacity.
    always_comb
    begin
        for (int k = 0; k < WORD_BITS; k++)
        begin
            avail[k] = !rdata[k] && (XW'(k) < remain);
        end
    end

    always_comb
    begin
        pick  = '0;
        found = 1'b0;
        for (int k = WORD_BITS - 1; k >= 0; k--)
        begin
            if (avail[k])
            begin
                pick  = OW'(k);
                found = 1'b1;
            end
        end
    end

    assign off      = OW'(idx_reg - base_reg);
    assign set_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << pick;
    assign clr_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << off;
    assign num_in   = XW'(item.entry_number);

    always_comb
    begin
        sts           = '0;
        sts.found     = found;
        sts.last_word = (word_reg == LAST_WORD);
        sts.scan_end  = (word_reg == LAST_WORD) || (base_end >= cap_eff);
        sts.idx_here  = (idx_reg < base_end);
        sts.bit_set   = rdata[off];
        sts.range_bad = (num_in == '0) || (num_in > cap_eff);
    end

    // The scan reads one word ahead so that the next word's data is ready as soon as the scan advances to it.
    assign word_ahead = (word_reg == LAST_WORD) ? word_reg : (word_reg + AW'(1));

    always_comb
    begin
        priority if (cmd.rd_cur)
        begin
            raddr = word_reg;
        end
        else if (cmd.rd_next)
        begin
            raddr = word_ahead;
        end
        else
        begin
            raddr = '0;
        end
    end

    assign we = cmd.clear || cmd.wr_set || cmd.wr_clr;

    always_comb
    begin
        priority if (cmd.clear)
        begin
            wdata = '0;
        end
        else if (cmd.wr_set)
        begin
            wdata = rdata | set_mask;
        end
        else
        begin
            wdata = rdata & ~clr_mask;
        end
    end

    bffa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (word_reg),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        word_next = word_reg;
        base_next = base_reg;
        if (cmd.load)
        begin
            word_next = '0;
            base_next = '0;
        end
        else if (cmd.advance)
        begin
            word_next = word_reg + AW'(1);
            base_next = base_end;
        end
    end

    always_comb
    begin
        used_next = used_reg;
        if (cmd.wr_set)
        begin
            used_next = used_reg + UCW'(1);
        end
        else if (cmd.wr_clr && (used_reg != '0))
        begin
            used_next = used_reg - UCW'(1);
        end
    end

    assign used_x = XW'(used_next);
    assign free_x = (cap_eff > used_x) ? (cap_eff - used_x) : '0;

    always_comb
    begin
        result_next.status           = cmd.status;
        result_next.allocated_number = cmd.grant ? NUM_W'(base_reg + XW'(pick) + XW'(1)) : '0;
        result_next.free_count       = NUM_W'(free_x);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            word_reg     <= '0;
            base_reg     <= '0;
            used_reg     <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            word_reg <= word_next;
            base_reg <= base_next;
            used_reg <= used_next;
            done_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg <= num_in - XW'(1);
        end
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_full_means_zero_free: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == ST_FULL) |-> result.free_count == '0)
        else $error("full reported while free entries remain");

    a_no_number_on_failure: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status != ST_OK) |-> result.allocated_number == '0)
        else $error("number returned on a failed transfer");

    a_set_needs_candidate: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_set |-> sts.found)
        else $error("bit set without a free candidate");

    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= MAP_U)
        else $error("used count exceeds map size");
`endif

endmodule

`default_nettype wire

// ===== rtl/bitmap_first_free_allocator_core.sv =====
// Top level of the first-fit bitmap allocator: controller plus datapath.
`default_nettype none

// First-fit bitmap allocator. Pulse start while busy is low to hand over one
// operation: allocate returns the lowest free 1-based number not above the
// capacity, free releases a given number. Every operation gives exactly one
// result, shown on result for the single cycle in which done is high; the
// receiver must take it then. The bitmap sits in a RAM of MAP_BITS/WORD_BITS
// words (rounded up), and one word is examined per cycle. An allocate keeps
// busy high while it walks the words up to the one that holds its bit, with
// done in the cycle after, when busy is low again and the next start can
// follow. A free of entry n walks to word (n-1)/WORD_BITS and then does a
// read-modify-write. A free with a number out of range answers without
// leaving idle. After reset the block runs a clearing pass over every word
// with busy high; capacity writes are taken at any time but must only be
// made while the block is idle.
module bitmap_first_free_allocator_core
    import bffa_pkg::*;
#(
    parameter int MAP_BITS  = 8192,
    parameter int WORD_BITS = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire in_item_t         item,
    output logic                  busy,
    input  wire logic             cfg_we,
    input  wire logic [CAP_W-1:0] cfg_wdata,
    output logic                  done,
    output result_t               result
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    bffa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (item.op),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    bffa_dp #(
        .MAP_BITS  (MAP_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .cmd       (cmd),
        .sts       (sts),
        .done      (done),
        .result    (result)
    );

endmodule

`default_nettype wire
